/* sv/sdss_pkg.sv */
// ----------------------------------------------------------------------------
// sdss_pkg
// Shared types, constants and character helpers of the digit scanner.
// ----------------------------------------------------------------------------
package sdss_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_BITS = $clog2(SLOT_COUNT);

	localparam logic [7:0] END_MARKER_RESET = 8'd10;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef logic [7:0] char_t;
	typedef char_t [SLOT_COUNT-1:0] char_row_t;

	// Write request from the scan front end into the frame buffer
	typedef struct packed {
		logic  store;
		char_t ch;
	} sdss_wr_t;

	localparam char_row_t SHOWN_RESET = {
		8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38
	};

	function automatic logic [7:0] char_to_seg(input char_t ch);
		logic [7:0] seg;
		case (ch)
			8'h31:   seg = 8'b00010100;
			8'h32:   seg = 8'b11001101;
			8'h33:   seg = 8'b01011101;
			8'h34:   seg = 8'b00011110;
			8'h35:   seg = 8'b01011011;
			8'h36:   seg = 8'b11011011;
			8'h37:   seg = 8'b00010101;
			8'h38:   seg = 8'b11011111;
			8'h39:   seg = 8'b01011111;
			default: seg = 8'b11010111;
		endcase
		return seg;
	endfunction

	function automatic logic is_letter(input char_t ch);
		return ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
	endfunction

endpackage

/* sv/sdss_frame_buffer.sv */
// ----------------------------------------------------------------------------
// sdss_frame_buffer
// Eight-slot pending buffer and the display store it loads when full.
// ----------------------------------------------------------------------------
module sdss_frame_buffer
	import sdss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sdss_wr_t  wr,
	output logic      loaded,
	output char_row_t shown
);

	char_row_t             pending_q;
	char_row_t             shown_q;
	logic [SLOT_BITS-1:0]  count_q;
	char_row_t             full_row;

	assign loaded = wr.store && (count_q == SLOT_BITS'(SLOT_COUNT - 1));
	assign shown  = shown_q;

	// Last slot arrives with the strobe itself: merge it in for the copy
	always_comb begin
		full_row = pending_q;
		full_row[SLOT_COUNT-1] = wr.ch;
	end

	always_ff @(posedge clk) begin
		if (wr.store) begin
			pending_q[count_q] <= wr.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			shown_q <= SHOWN_RESET;
		end else if (wr.store) begin
			if (loaded) begin
				count_q <= '0;
				shown_q <= full_row;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

/* sv/serial_digit_seven_segment_scanner_unit.sv */
// ----------------------------------------------------------------------------
// serial_digit_seven_segment_scanner_unit
// Serial character collector and four-phase scan driver for eight digits.
// ----------------------------------------------------------------------------
// Each beat is either a received byte or a scan tick and yields exactly one
// result beat. A beat is held in the input register and is then worked into
// the result register, so the unit takes one beat per clock when the output
// is not stalled; the buffer, scan phase and segment latch update in that one
// pass. Letters and the end marker are dropped; the eighth stored byte copies
// the buffer to the display, which becomes visible on the following ticks.
// ----------------------------------------------------------------------------
module serial_digit_seven_segment_scanner_unit
	import sdss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] digit_enable,
	output logic [7:0] first_chip_segments,
	output logic [7:0] second_chip_segments,
	output logic       frame_loaded
);

	logic [7:0]  end_marker_q;
	logic        valid_s1;
	logic        op_s1;
	char_t       byte_s1;
	logic        advance;

	logic [2:0]  phase_q;
	logic [15:0] held_q;
	logic [2:0]  phase_nxt;
	logic [15:0] held_nxt;
	logic [3:0]  enable_nxt;
	char_t       lo_ch;
	char_t       hi_ch;

	sdss_wr_t    wr;
	logic        loaded;
	char_row_t   shown;

	logic        out_valid_q;
	logic [3:0]  enable_q;
	logic [15:0] seg_q;
	logic        loaded_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_marker_q <= END_MARKER_RESET;
		end else if (cfg_we) begin
			end_marker_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	assign wr.store = advance && (op_s1 == OP_BYTE) && (byte_s1 != end_marker_q)
		&& !is_letter(byte_s1);
	assign wr.ch    = byte_s1;

	sdss_frame_buffer u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.loaded (loaded),
		.shown  (shown)
	);

	// Scan: phases one to four, anything else restarts at one
	always_comb begin
		phase_nxt = phase_q;
		held_nxt  = held_q;
		lo_ch     = shown[3];
		hi_ch     = shown[7];
		if (op_s1 == OP_TICK) begin
			if ((phase_q >= 3'd1) && (phase_q <= 3'd3)) begin
				phase_nxt = phase_q + 3'd1;
			end else begin
				phase_nxt = 3'd1;
			end
			case (phase_nxt)
				3'd2: begin
					lo_ch = shown[2];
					hi_ch = shown[6];
				end
				3'd3: begin
					lo_ch = shown[1];
					hi_ch = shown[5];
				end
				3'd4: begin
					lo_ch = shown[0];
					hi_ch = shown[4];
				end
				default: begin
					lo_ch = shown[3];
					hi_ch = shown[7];
				end
			endcase
			held_nxt = {char_to_seg(hi_ch), char_to_seg(lo_ch)};
		end
	end

	always_comb begin
		case (phase_nxt)
			3'd1:    enable_nxt = 4'b0001;
			3'd2:    enable_nxt = 4'b0010;
			3'd3:    enable_nxt = 4'b0100;
			3'd4:    enable_nxt = 4'b1000;
			default: enable_nxt = 4'b0000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			held_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			held_q  <= held_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			enable_q <= enable_nxt;
			seg_q    <= held_nxt;
			loaded_q <= loaded;
		end
	end

	assign out_valid            = out_valid_q;
	assign digit_enable         = enable_q;
	assign first_chip_segments  = seg_q[7:0];
	assign second_chip_segments = seg_q[15:8];
	assign frame_loaded         = loaded_q;

endmodule
